// ===== design/pds_pkg.sv =====
// ----------------------------------------------------------------------------
// pds_pkg
// Shared sizes, record types and control groups of the polygon depth sorter.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int KEY_W       = 32;
  localparam int TAG_W       = 16;
  localparam int STEP_W      = 16;
  localparam int POS_W       = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int PROD_W      = POS_W + STEP_W;

  localparam logic [STEP_W-1:0] BIAS_STEP_RESET = 16'd6554;
  localparam logic [KEY_W-1:0]  KEY_MIN         = {1'b1, {(KEY_W-1){1'b0}}};

  // One record as held in a sorter cell.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

  // Accepted item waiting for its bias.
  typedef struct packed {
    logic             valid;
    logic             store;
    logic             last;
    logic [POS_W-1:0] pos;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } load_t;

  // Biased item on its way into the cell chain.
  typedef struct packed {
    logic             valid;
    logic             store;
    logic             last;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } ins_t;

  // Chain-wide controls.
  typedef struct packed {
    logic ins_en;
    logic shift_en;
  } cell_ctl_t;

endpackage

// ===== design/pds_bias.sv =====
// ----------------------------------------------------------------------------
// pds_bias
// Subtracts position times step from the depth key, saturating low; registered.
// ----------------------------------------------------------------------------
module pds_bias (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pds_pkg::load_t               load_i,
  input  logic [pds_pkg::STEP_W-1:0]   bias_step_i,
  output pds_pkg::ins_t                ins_o
);

  logic [pds_pkg::PROD_W-1:0] prod;
  logic [pds_pkg::KEY_W:0]    diff;
  logic [pds_pkg::KEY_W-1:0]  biased;
  pds_pkg::ins_t              ins_q;

  assign prod = pds_pkg::PROD_W'(load_i.pos) * pds_pkg::PROD_W'(bias_step_i);
  assign diff = {load_i.key[pds_pkg::KEY_W-1], load_i.key}
              - {{(pds_pkg::KEY_W + 1 - pds_pkg::PROD_W){1'b0}}, prod};

  // Below the most negative key when the 33-bit sign and bit 31 disagree.
  always_comb begin
    if (diff[pds_pkg::KEY_W] && !diff[pds_pkg::KEY_W-1]) begin
      biased = pds_pkg::KEY_MIN;
    end else begin
      biased = diff[pds_pkg::KEY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ins_q <= '0;
    end else begin
      ins_q <= '{valid: load_i.valid, store: load_i.store, last: load_i.last,
                 key: biased, tag: load_i.tag};
    end
  end

  assign ins_o = ins_q;

endmodule

// ===== design/pds_cell.sv =====
// ----------------------------------------------------------------------------
// pds_cell
// One slot of the insertion chain: keeps a record, yields to a larger key.
// ----------------------------------------------------------------------------
module pds_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pds_pkg::cell_ctl_t   ctl_i,
  input  pds_pkg::ins_t        new_i,
  input  pds_pkg::rec_t        prev_rec_i,
  input  logic                 prev_ins_i,
  input  pds_pkg::rec_t        next_rec_i,
  output pds_pkg::rec_t        rec_o,
  output logic                 ins_o
);

  logic                       valid_q, valid_d;
  logic [pds_pkg::KEY_W-1:0]  key_q, key_d;
  logic [pds_pkg::TAG_W-1:0]  tag_q, tag_d;

  // Strict compare keeps equal keys in load order.
  assign ins_o = !valid_q || ($signed(key_q) < $signed(new_i.key));

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    tag_d   = tag_q;
    if (ctl_i.ins_en && ins_o) begin
      if (prev_ins_i) begin
        valid_d = prev_rec_i.valid;
        key_d   = prev_rec_i.key;
        tag_d   = prev_rec_i.tag;
      end else begin
        valid_d = 1'b1;
        key_d   = new_i.key;
        tag_d   = new_i.tag;
      end
    end else if (ctl_i.shift_en) begin
      valid_d = next_rec_i.valid;
      key_d   = next_rec_i.key;
      tag_d   = next_rec_i.tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign rec_o = '{valid: valid_q, key: key_q, tag: tag_q};

endmodule

// ===== design/polygon_depth_sorter.sv =====
// ----------------------------------------------------------------------------
// polygon_depth_sorter
// Painter's-order sorter: biased depth keys, farthest record first.
// ----------------------------------------------------------------------------
// Records are taken one per cycle while a batch loads; each passes the load
// register and a bias stage (one small multiply and a saturating subtract)
// and then enters a chain of MAX_RECORDS cells, where it is inserted in place.
// Once the record marked last is accepted the input stalls, and once it
// reaches the chain the chain shifts its contents out of cell 0, one result
// per cycle while the sink is ready. The cell chain does one insert or one
// shift per cycle. Records beyond capacity are dropped and flagged.
module polygon_depth_sorter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pds_pkg::STEP_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [pds_pkg::KEY_W-1:0] depth_key_i,
  input  logic [pds_pkg::TAG_W-1:0]     item_tag_i,
  input  logic                          last_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pds_pkg::TAG_W-1:0]     sorted_tag_o,
  output logic signed [pds_pkg::KEY_W-1:0] sorted_key_o,
  output logic                          overflow_o,
  output logic                          last_out_o
);

  localparam int N = pds_pkg::MAX_RECORDS;

  logic [pds_pkg::STEP_W-1:0] bias_step_q;
  logic [pds_pkg::CNT_W-1:0]  count_q, count_d;
  logic                       ovf_seen_q, ovf_seen_d;
  logic                       batch_ovf_q, batch_ovf_d;
  logic                       busy_q, busy_d;
  logic                       drain_q, drain_d;
  pds_pkg::load_t             load_q, load_d;
  pds_pkg::ins_t              ins;
  pds_pkg::cell_ctl_t         ctl;
  logic                       in_accept, drop, drain_done;

  pds_pkg::rec_t              cells    [N];
  pds_pkg::rec_t              prev_rec [N];
  pds_pkg::rec_t              next_rec [N];
  logic [N-1:0]               ins_flag;
  logic [N-1:0]               prev_ins;
  logic [N-1:0]               valid_vec;

  assign in_ready_o = !busy_q;
  assign in_accept  = in_valid_i && in_ready_o;
  assign drop       = (count_q == pds_pkg::CNT_W'(N));

  always_comb begin
    count_d     = count_q;
    ovf_seen_d  = ovf_seen_q;
    batch_ovf_d = batch_ovf_q;
    busy_d      = busy_q;
    drain_d     = drain_q;
    load_d.valid = in_accept;
    load_d.store = !drop;
    load_d.last  = last_item_i;
    load_d.pos   = count_q[pds_pkg::POS_W-1:0];
    load_d.key   = depth_key_i;
    load_d.tag   = item_tag_i;
    if (in_accept) begin
      if (last_item_i) begin
        count_d     = '0;
        ovf_seen_d  = 1'b0;
        batch_ovf_d = ovf_seen_q || drop;
        busy_d      = 1'b1;
      end else if (drop) begin
        ovf_seen_d = 1'b1;
      end else begin
        count_d = count_q + pds_pkg::CNT_W'(1);
      end
    end
    if (ins.valid && ins.last) begin
      drain_d = 1'b1;
    end
    if (drain_done) begin
      drain_d = 1'b0;
      busy_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_step_q <= pds_pkg::BIAS_STEP_RESET;
      count_q     <= '0;
      ovf_seen_q  <= 1'b0;
      batch_ovf_q <= 1'b0;
      busy_q      <= 1'b0;
      drain_q     <= 1'b0;
      load_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        bias_step_q <= cfg_wdata_i;
      end
      count_q     <= count_d;
      ovf_seen_q  <= ovf_seen_d;
      batch_ovf_q <= batch_ovf_d;
      busy_q      <= busy_d;
      drain_q     <= drain_d;
      load_q      <= load_d;
    end
  end

  pds_bias u_bias (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load_q),
    .bias_step_i (bias_step_q),
    .ins_o       (ins)
  );

  assign ctl.ins_en   = ins.valid && ins.store;
  assign ctl.shift_en = out_valid_o && out_ready_i;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_rec[i] = '0;
      assign prev_ins[i] = 1'b0;
    end else begin : g_body
      assign prev_rec[i] = cells[i-1];
      assign prev_ins[i] = ins_flag[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign next_rec[i] = '0;
    end else begin : g_mid
      assign next_rec[i] = cells[i+1];
    end
    assign valid_vec[i] = cells[i].valid;

    pds_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .new_i      (ins),
      .prev_rec_i (prev_rec[i]),
      .prev_ins_i (prev_ins[i]),
      .next_rec_i (next_rec[i]),
      .rec_o      (cells[i]),
      .ins_o      (ins_flag[i])
    );
  end

  assign out_valid_o  = drain_q && cells[0].valid;
  assign sorted_tag_o = cells[0].tag;
  assign sorted_key_o = cells[0].key;
  assign overflow_o   = batch_ovf_q;
  assign last_out_o   = !cells[1].valid;
  assign drain_done   = drain_q && (!cells[0].valid || (out_ready_i && last_out_o));

  // Occupied cells form a contiguous run from cell 0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + N'(1)) & valid_vec) == '0)
    else $error("cell chain has a hole");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cells[1].valid |-> ($signed(cells[0].key) >= $signed(cells[1].key)))
    else $error("head cells out of order");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.ins_en && ctl.shift_en))
    else $error("insert during drain");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> !in_ready_o)
    else $error("input open while draining");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pds_pkg::CNT_W'(N))
    else $error("record count past capacity");

endmodule
